[rtl/sodt_pkg.sv]
// sodt_pkg: types and constants shared by the switch output delay timer
// no dependencies
package sodt_pkg;

	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;
	localparam int LIMIT_W = 24;
	localparam int VALUE_W = 14;
	localparam int BASE_W  = 10;

	localparam logic [VALUE_W-1:0] RESET_DELAY_VALUE = 14'd10;
	localparam logic [BASE_W-1:0]  RESET_BASE_TIME   = 10'd23;

	typedef enum logic [1:0] {
		MODE_DIRECT = 2'd0,
		MODE_OFF    = 2'd1,
		MODE_ON     = 2'd2,
		MODE_PULSE  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_MODE  = 2'd0,
		REG_VALUE = 2'd1,
		REG_BASE  = 2'd2,
		REG_NONE  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		mode_t              mode;
		logic [LIMIT_W-1:0] limit;
	} cfg_t;

endpackage

[rtl/sodt_if.sv]
// sodt_in_if / sodt_out_if: valid-ready channels of the delay timer
// no dependencies
interface sodt_in_if;
	logic valid;
	logic ready;
	logic detect;
	logic short_active;
	modport source (output valid, output detect, output short_active, input ready);
	modport sink (input valid, input detect, input short_active, output ready);
endinterface

interface sodt_out_if;
	logic valid;
	logic ready;
	logic out_level;
	modport source (output valid, output out_level, input ready);
	modport sink (input valid, input out_level, output ready);
endinterface

[rtl/sodt_cfg.sv]
// sodt_cfg: apb register file, keeps the delay limit product up to date
// depends on sodt_pkg
module sodt_cfg import sodt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);
	localparam logic [LIMIT_W-1:0] RESET_LIMIT =
		LIMIT_W'(RESET_DELAY_VALUE) * LIMIT_W'(RESET_BASE_TIME);

	mode_t              mode_q;
	logic [VALUE_W-1:0] value_q;
	logic [BASE_W-1:0]  base_q;
	logic [LIMIT_W-1:0] limit_q;
	logic               wr;
	reg_idx_t           idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_DIRECT;
			value_q <= RESET_DELAY_VALUE;
			base_q  <= RESET_BASE_TIME;
			limit_q <= RESET_LIMIT;
		end else if (wr) begin
			case (idx)
				REG_MODE: mode_q <= mode_t'(pwdata[1:0]);
				REG_VALUE: begin
					value_q <= pwdata[VALUE_W-1:0];
					limit_q <= LIMIT_W'(pwdata[VALUE_W-1:0]) * LIMIT_W'(base_q);
				end
				REG_BASE: begin
					base_q  <= pwdata[BASE_W-1:0];
					limit_q <= LIMIT_W'(value_q) * LIMIT_W'(pwdata[BASE_W-1:0]);
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MODE:  prdata = DATA_W'(mode_q);
			REG_VALUE: prdata = DATA_W'(value_q);
			REG_BASE:  prdata = DATA_W'(base_q);
			default:   prdata = '0;
		endcase
	end

	assign cfg.mode  = mode_q;
	assign cfg.limit = limit_q;
endmodule

[rtl/sodt_core.sv]
// sodt_core: per-tick mode logic, saturating tick counter and result register
// depends on sodt_pkg and the channel interfaces
module sodt_core import sodt_pkg::*; #(
	parameter int COUNT_WIDTH = 24
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	sodt_in_if.sink    in_ch,
	sodt_out_if.source out_ch
);
	localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

	logic                   level_q;
	logic                   pulse_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic                   out_valid_q;
	logic                   out_level_q;

	logic                   accept;
	logic                   level_d;
	logic                   pulse_d;
	logic                   clear;
	logic                   over;
	logic                   under;
	logic [COUNT_WIDTH-1:0] count_base;
	logic [COUNT_WIDTH-1:0] count_d;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	assign over  = CMP_W'(count_q) > CMP_W'(cfg.limit);
	assign under = CMP_W'(count_q) < CMP_W'(cfg.limit);

	always_comb begin
		level_d = level_q;
		pulse_d = pulse_q;
		clear   = 1'b0;
		if (!in_ch.short_active) begin
			case (cfg.mode)
				MODE_DIRECT: begin
					level_d = in_ch.detect;
					clear   = 1'b1;
				end
				MODE_OFF: begin
					if (in_ch.detect) begin
						level_d = 1'b1;
						clear   = 1'b1;
					end else if (over) begin
						level_d = 1'b0;
					end
				end
				MODE_ON: begin
					if (!in_ch.detect) begin
						level_d = 1'b0;
						clear   = 1'b1;
					end else if (over) begin
						level_d = 1'b1;
					end
				end
				default: begin
					if (in_ch.detect || pulse_q) begin
						level_d = under;
						pulse_d = under;
					end else begin
						level_d = 1'b0;
						clear   = 1'b1;
					end
				end
			endcase
		end
	end

	// saturating count, restarts at one after a clear
	assign count_base = clear ? '0 : count_q;
	assign count_d    = (&count_base) ? count_base : count_base + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q     <= 1'b0;
			pulse_q     <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				level_q <= level_d;
				pulse_q <= pulse_d;
				count_q <= count_d;
			end
			if (accept) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) out_level_q <= level_d;
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.out_level = out_level_q;
endmodule

[rtl/switch_output_delay_timer.sv]
// Switch output delay timer. One tick transaction is accepted every clock cycle
// unless the result register is stalled; its output level appears there in the
// cycle after acceptance and the input stays ready whenever that register is empty
// or being taken in the same cycle. The per-tick cost is two compares of the tick
// counter against the delay limit and one increment. The limit delay_value * base_time
// is formed by a 14x10 multiplier in the register block at the moment either
// register is written, so a tick may follow a configuration write directly. The tick
// counter saturates at 2**COUNT_WIDTH - 1 and keeps running during a short circuit.
// depends on sodt_pkg, sodt_if, sodt_cfg, sodt_core
module switch_output_delay_timer import sodt_pkg::*; #(
	parameter int COUNT_WIDTH = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	sodt_in_if.sink           in_ch,
	sodt_out_if.source        out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);
	cfg_t cfg;

	sodt_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sodt_core #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);
endmodule

[rtl/sodt_checker.sv]
// sodt_assertions: port-level assertions for the switch output delay timer
// bound to switch_output_delay_timer, no package dependencies
module sodt_assertions (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic out_level
);
	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_level))
		else $error("stalled result changed");

	// every transaction gives a result in the next cycle
	a_in_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> out_valid)
		else $error("missing result after transaction");

	// a new result only follows a transaction
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_acc))
		else $error("result without transaction");

	// a full, stalled result register blocks the input
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input ready while result stalled");
endmodule

bind switch_output_delay_timer sodt_assertions u_sodt_assertions (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_level (out_ch.out_level)
);
